### src/aosl_pkg.sv
// ---------------------------------------------------------------------------
// aosl_pkg
// shared types, codes and the level lfsr step for the skip list index
// ---------------------------------------------------------------------------
package aosl_pkg;

  localparam int KEY_W   = 64;
  localparam int VALUE_W = 32;
  localparam int LIVE_W  = 10;
  localparam int SEED_W  = 32;

  localparam logic [SEED_W-1:0] LFSR_MASK = 32'h8020_0003;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_SEARCH   = 2'd1,
    CMD_TRUNCATE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_ORDER     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] found_value;
    logic [KEY_W-1:0]   first_key;
    logic [LIVE_W-1:0]  live_count;
  } rsp_t;

  // galois step, shifting right
  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    lfsr_step = (s >> 1) ^ (s[0] ? LFSR_MASK : '0);
  endfunction

endpackage

### src/aosl_ram.sv
// ---------------------------------------------------------------------------
// aosl_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module aosl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/append_only_skiplist_index_core.sv
// ---------------------------------------------------------------------------
// append_only_skiplist_index_core
// append-only ordered key/value index kept as a skip list over a ring of
// node slots, with insert, search and truncate-through-key requests
// ---------------------------------------------------------------------------
//
//  channel   | ports                 | handshake
//  ----------+-----------------------+--------------------------------------
//  request   | start, busy, req      | taken when start high and busy low
//  result    | done, rsp             | done strobe for one cycle, no stall
//  config    | cfg_we, cfg_wdata     | seed written when cfg_we high
//
//  one request at a time, busy high until the result strobe; no stall
//  insert: lfsr draws until one ends the tower or it hits MAX_LEVELS,
//    then place, link A and link B per linked level, first-key read, output
//  search/truncate: per level a start, a link fetch once past the head, a
//    check and compare per key; then end, hit value, first-key read, output
//  synchronous reset, no clearing pass: stores are read only where written
//
module append_only_skiplist_index_core #(
  parameter int POOL_SLOTS = 1024,
  parameter int MAX_LEVELS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  aosl_pkg::req_t              req,
  input  logic                        cfg_we,
  input  logic [aosl_pkg::SEED_W-1:0] cfg_wdata,
  output logic                        done,
  output aosl_pkg::rsp_t              rsp
);
  import aosl_pkg::*;

  // slot index, level index and level count widths
  localparam int SW  = $clog2(POOL_SLOTS);
  localparam int LIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LW  = $clog2(MAX_LEVELS + 1);
  localparam int AW  = SW + LIW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(POOL_SLOTS - 1);
  localparam logic [SW:0]   RING      = (SW+1)'(POOL_SLOTS - 1);
  localparam logic [LW-1:0] TOP       = LW'(MAX_LEVELS);

  typedef enum logic [3:0] {
    S_IDLE, S_DRAW, S_PLACE, S_LINK_A, S_LINK_B,
    S_LEVEL, S_WAIT_LINK, S_CHECK_N, S_CMP,
    S_SRCH_END, S_VALUE, S_TRUNC_END, S_FIRST, S_OUT
  } state_t;

  state_t              state;
  logic [1:0]          cmd;
  logic [KEY_W-1:0]    k;
  logic [VALUE_W-1:0]  v;
  logic [SEED_W-1:0]   lfsr;
  logic [LW-1:0]       h;
  logic [LW-1:0]       levels;
  logic [LIW-1:0]      lvl;
  logic [SW-1:0]       newest;
  logic [SW-1:0]       count;
  logic [KEY_W-1:0]    last_key;
  logic [SW-1:0]       head [MAX_LEVELS];
  logic [SW-1:0]       tail [MAX_LEVELS];
  logic [SW-1:0]       x;
  logic [SW-1:0]       n;
  logic [KEY_W-1:0]    x_key;
  logic [1:0]          status;
  logic [VALUE_W-1:0]  found;
  logic                has_first;

  // ram ports
  logic                key_we, link_we;
  logic [SW-1:0]       key_waddr, key_raddr;
  logic [AW-1:0]       link_waddr, link_raddr;
  logic [SW-1:0]       link_wdata, link_rdata;
  logic [KEY_W-1:0]    key_rdata;
  logic [VALUE_W-1:0]  value_rdata;

  // next-cycle helpers
  logic [SW-1:0]       slot_next;
  logic [LW-1:0]       h_cap;
  logic [SEED_W-1:0]   lfsr_next;
  logic [SW:0]         ring_dist;

  assign busy      = (state != S_IDLE);
  assign slot_next = (newest == LAST_SLOT) ? SW'(1) : newest + SW'(1);
  assign h_cap     = (h > levels) ? levels + LW'(1) : h;
  assign lfsr_next = lfsr_step(lfsr);
  assign ring_dist = ({1'b0, newest} >= {1'b0, head[0]})
                     ? {1'b0, newest} - {1'b0, head[0]}
                     : {1'b0, newest} + RING - {1'b0, head[0]};

  // ram addressing
  assign key_we     = (state == S_PLACE);
  assign key_waddr  = slot_next;
  assign key_raddr  = (state == S_FIRST) ? head[0] : n;
  assign link_raddr = (state == S_LEVEL) ? {x, lvl} : {n, lvl};

  always_comb begin
    link_we    = 1'b0;
    link_waddr = {newest, lvl};
    link_wdata = '0;
    if (state == S_LINK_A && tail[lvl] != '0) begin
      // old tail of this level now points at the new slot
      link_we    = 1'b1;
      link_waddr = {tail[lvl], lvl};
      link_wdata = newest;
    end else if (state == S_LINK_B) begin
      // new slot ends the level
      link_we = 1'b1;
    end
  end

  aosl_ram #(.WIDTH(KEY_W), .DEPTH(POOL_SLOTS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(k),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  aosl_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_SLOTS)) u_value_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(v),
    .raddr(x), .rdata(value_rdata)
  );

  aosl_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS << LIW)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      lfsr     <= SEED_W'(1);
      levels   <= '0;
      newest   <= SW'(1);
      count    <= '0;
      last_key <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        // zero seed would lock the lfsr, load one instead
        lfsr <= (cfg_wdata == '0) ? SEED_W'(1) : cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd    <= req.command;
            k      <= req.key;
            v      <= req.value;
            status <= ST_OK;
            found  <= '0;
            h      <= LW'(1);
            x      <= '0;
            lvl    <= LIW'(levels - LW'(1));
            unique case (req.command)
              CMD_INSERT: begin
                if (count == LAST_SLOT) begin
                  status <= ST_FULL;
                  state  <= S_FIRST;
                end else if (req.key < last_key) begin
                  status <= ST_ORDER;
                  state  <= S_FIRST;
                end else begin
                  state <= S_DRAW;
                end
              end
              CMD_SEARCH: begin
                if (levels == '0) begin
                  status <= ST_NOT_FOUND;
                  state  <= S_FIRST;
                end else begin
                  state <= S_LEVEL;
                end
              end
              CMD_TRUNCATE: state <= (levels == '0) ? S_FIRST : S_LEVEL;
              default:      state <= S_FIRST;
            endcase
          end
        end
        // tower height: one lfsr step per draw
        S_DRAW: begin
          if (h < TOP) begin
            lfsr <= lfsr_next;
            if (lfsr_next[1:0] == 2'b00) begin
              h <= h + LW'(1);
            end else begin
              state <= S_PLACE;
            end
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          h        <= h_cap;
          if (h_cap > levels) begin
            levels <= h_cap;
          end
          newest   <= slot_next;
          count    <= count + SW'(1);
          last_key <= k;
          lvl      <= '0;
          state    <= S_LINK_A;
        end
        S_LINK_A: begin
          if (tail[lvl] == '0) begin
            head[lvl] <= newest;
          end
          state <= S_LINK_B;
        end
        S_LINK_B: begin
          tail[lvl] <= newest;
          if (LW'(lvl) + LW'(1) == h) begin
            state <= S_FIRST;
          end else begin
            lvl   <= lvl + LIW'(1);
            state <= S_LINK_A;
          end
        end
        // descent: start of a level
        S_LEVEL: begin
          if (x == '0) begin
            n     <= head[lvl];
            state <= S_CHECK_N;
          end else begin
            state <= S_WAIT_LINK;
          end
        end
        S_WAIT_LINK: begin
          n     <= link_rdata;
          state <= S_CHECK_N;
        end
        S_CHECK_N: begin
          // reads of key and link for n are issued this cycle
          state <= (n == '0) ? S_CMP : S_CMP;
        end
        S_CMP: begin
          if (n != '0 && key_rdata <= k) begin
            x     <= n;
            x_key <= key_rdata;
            n     <= link_rdata;
            state <= S_CHECK_N;
          end else begin
            if (cmd == CMD_TRUNCATE) begin
              head[lvl] <= n;
              if (n == '0) begin
                tail[lvl] <= '0;
              end
            end
            if (lvl == '0) begin
              state <= (cmd == CMD_TRUNCATE) ? S_TRUNC_END : S_SRCH_END;
            end else begin
              lvl   <= lvl - LIW'(1);
              state <= S_LEVEL;
            end
          end
        end
        S_SRCH_END: begin
          if (x != '0 && x_key == k) begin
            state <= S_VALUE;
          end else begin
            status <= ST_NOT_FOUND;
            state  <= S_FIRST;
          end
        end
        S_VALUE: begin
          found <= value_rdata;
          state <= S_FIRST;
        end
        S_TRUNC_END: begin
          if (head[0] == '0) begin
            count <= '0;
          end else begin
            count <= SW'(ring_dist + (SW+1)'(1));
          end
          state <= S_FIRST;
        end
        // smallest live key is read from the head of the bottom level
        S_FIRST: begin
          has_first <= (count != '0) && (levels != '0) && (head[0] != '0);
          state     <= S_OUT;
        end
        S_OUT: begin
          rsp.status      <= status;
          rsp.found_value <= found;
          rsp.first_key   <= has_first ? key_rdata : '0;
          rsp.live_count  <= LIVE_W'(count);
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("request finished without a result");
  a_levels: assert property (@(posedge clk) disable iff (rst) levels <= TOP)
    else $error("levels in use beyond the maximum");
  a_count: assert property (@(posedge clk) disable iff (rst) count <= LAST_SLOT)
    else $error("live count beyond the pool");
  a_full: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_FULL |-> rsp.live_count == LIVE_W'(LAST_SLOT))
    else $error("pool full reported below capacity");
`endif

endmodule

### verif/tb_append_only_skiplist_index_core.sv
// ---------------------------------------------------------------------------
// tb_append_only_skiplist_index_core
// self-checking bench for the skip list index: a behavioural copy of the
// index predicts every result, which is compared against the strobed output
// ---------------------------------------------------------------------------
module tb_append_only_skiplist_index_core;
  timeunit 1ns;
  timeprecision 1ps;
  import aosl_pkg::*;

  localparam int SLOTS  = 1024;
  localparam int LEVELS = 12;
  localparam int SETTLE = 64;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic cfg_we = 1'b0;
  logic [SEED_W-1:0] cfg_wdata = '0;
  logic done;
  rsp_t rsp;

  append_only_skiplist_index_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .rsp(rsp)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- shadow copy of the index ----
  logic [KEY_W-1:0]   shadow_key [SLOTS];
  logic [VALUE_W-1:0] shadow_val [SLOTS];
  logic [9:0]         shadow_link[SLOTS*LEVELS];
  logic [9:0]         head_ptr   [LEVELS];
  logic [9:0]         tail_ptr   [LEVELS];
  int                 levels_used;
  int                 newest;
  int                 oldest;
  int                 live;
  logic [KEY_W-1:0]   last_ins_key;
  logic [SEED_W-1:0]  height_lfsr;

  rsp_t expected_rsp[$];
  int   err_count = 0;
  int   gap_pct = 0;
  longint cycle_count = 0;

  function automatic int next_node(int slot, int lvl);
    return (slot == 0) ? int'(head_ptr[lvl]) : int'(shadow_link[slot*LEVELS + lvl]);
  endfunction

  function automatic void link_node(int slot, int lvl, int to);
    if (slot == 0) head_ptr[lvl] = to[9:0];
    else shadow_link[slot*LEVELS + lvl] = to[9:0];
  endfunction

  function automatic int ring_after(int slot);
    return slot % (SLOTS - 1) + 1;
  endfunction

  // last node with key <= k; optionally cut every level at that point
  function automatic int walk_down(logic [KEY_W-1:0] k, bit cut);
    int x;
    int n;
    x = 0;
    for (int i = levels_used - 1; i >= 0; i--) begin
      n = next_node(x, i);
      while (n != 0 && shadow_key[n] <= k) begin
        x = n;
        n = next_node(x, i);
      end
      if (cut) begin
        head_ptr[i] = n[9:0];
        if (n == 0) tail_ptr[i] = '0;
      end
    end
    return x;
  endfunction

  function automatic void shadow_reset();
    foreach (head_ptr[i]) begin
      head_ptr[i] = '0;
      tail_ptr[i] = '0;
    end
    levels_used = 0;
    newest = 1;
    oldest = 1;
    live = 0;
    last_ins_key = '0;
    height_lfsr = 32'd1;
  endfunction

  function automatic rsp_t index_result(req_t r);
    rsp_t o;
    int h;
    int slot;
    int x;
    logic [SEED_W-1:0] s;
    o = '0;
    o.status = ST_OK;
    case (cmd_t'(r.command))
      CMD_INSERT: begin
        if (live >= SLOTS - 1) o.status = ST_FULL;
        else if (r.key < last_ins_key) o.status = ST_ORDER;
        else begin
          h = 1;
          while (h < LEVELS) begin
            s = height_lfsr;
            height_lfsr = (s >> 1) ^ (s[0] ? 32'h8020_0003 : 32'h0);
            if (height_lfsr[1:0] != 2'b00) break;
            h++;
          end
          if (h > levels_used) begin
            h = levels_used + 1;
            levels_used = h;
          end
          slot = ring_after(newest);
          newest = slot;
          shadow_key[slot] = r.key;
          shadow_val[slot] = r.value;
          for (int i = 0; i < h; i++) begin
            link_node(int'(tail_ptr[i]), i, slot);
            link_node(slot, i, 0);
            tail_ptr[i] = slot[9:0];
          end
          if (live == 0) oldest = slot;
          live++;
          last_ins_key = r.key;
        end
      end
      CMD_SEARCH: begin
        x = walk_down(r.key, 1'b0);
        if (x != 0 && shadow_key[x] == r.key) o.found_value = shadow_val[x];
        else o.status = ST_NOT_FOUND;
      end
      CMD_TRUNCATE: begin
        if (levels_used > 0) begin
          void'(walk_down(r.key, 1'b1));
          if (head_ptr[0] == 0) begin
            live = 0;
            oldest = ring_after(newest);
          end else begin
            live = (newest + (SLOTS - 1) - int'(head_ptr[0])) % (SLOTS - 1) + 1;
            oldest = int'(head_ptr[0]);
          end
        end
      end
      default: ;
    endcase
    if (live > 0 && levels_used > 0 && head_ptr[0] != 0) o.first_key = shadow_key[head_ptr[0]];
    o.live_count = live[9:0];
    return o;
  endfunction

  // ---- checking ----
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result", rsp.first_key, 64'd0);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status != want.status)
          report_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.found_value != want.found_value)
          report_mismatch("found_value", 64'(rsp.found_value), 64'(want.found_value));
        if (rsp.first_key != want.first_key)
          report_mismatch("first_key", rsp.first_key, want.first_key);
        if (rsp.live_count != want.live_count)
          report_mismatch("live_count", 64'(rsp.live_count), 64'(want.live_count));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_append_only_skiplist_index_core: errors");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  // one request, held until taken; start is left high for a back-to-back follow-up unless a random gap is drawn
  task automatic send_request(cmd_t c, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    req_t r;
    r.command = c;
    r.key = k;
    r.value = v;
    req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rsp.push_back(index_result(r));
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // sender holds off until every expected result is in
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(logic [SEED_W-1:0] seed);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    height_lfsr = (seed != 0) ? seed : 32'd1;
    @(posedge clk);
  endtask

  // ---- tests ----
  task automatic test_directed();
    send_request(CMD_SEARCH, 64'd5, 32'hFFFF_FFFF);     // empty index search
    send_request(CMD_TRUNCATE, '1, '0);                  // empty index truncate
    send_request(CMD_NONE, 64'h55, 32'h1234);            // unused command
    send_request(CMD_INSERT, 64'd0, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 64'd0, 32'h0);              // duplicate key, newest wins
    send_request(CMD_SEARCH, 64'd0, '0);
    send_request(CMD_INSERT, 64'd10, 32'hA5A5_5A5A);
    send_request(CMD_INSERT, 64'd3, 32'h1);              // out of order
    send_request(CMD_INSERT, 64'd20, 32'h5A5A_A5A5);
    send_request(CMD_SEARCH, 64'd15, '0);                // absent
    send_request(CMD_SEARCH, 64'd20, '0);
    send_request(CMD_TRUNCATE, 64'd0, '0);
    send_request(CMD_TRUNCATE, 64'd5, '0);               // removes nothing
    send_request(CMD_SEARCH, 64'd10, '0);
    send_request(CMD_TRUNCATE, 64'd100, '0);             // drops everything
    send_request(CMD_INSERT, 64'd19, 32'h7);             // last key survives emptying
    send_request(CMD_INSERT, 64'd20, 32'h8);
    send_request(CMD_SEARCH, 64'd20, '0);
    drain();
  endtask

  task automatic test_seeds();
    write_seed(32'h0);                                   // zero seed loads one
    for (int i = 0; i < 6; i++) send_request(CMD_INSERT, 64'd30 + i, $urandom);
    write_seed(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_request(CMD_INSERT, 64'd40 + i, $urandom);
    send_request(CMD_SEARCH, 64'd42, '0);
    write_seed(32'h0000_0004);                           // seed with its two low bits zero
    for (int i = 0; i < 6; i++) send_request(CMD_INSERT, 64'd50 + i, $urandom);
    send_request(CMD_SEARCH, 64'd31, '0);
    drain();
  endtask

  // mostly inserts, so the index grows towards the full pool
  task automatic test_random(int n_items);
    logic [KEY_W-1:0] k;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (i % 80 == 40) begin
        gap_pct = (gap_pct == 0) ? 70 : (gap_pct == 70 ? 16 : 0);
        write_seed($urandom);
      end
      if (pick < 86) begin
        k = last_ins_key + $urandom_range(0, 3);
        if (pick < 2) k = last_ins_key - $urandom_range(1, 5);    // out of order
        send_request(CMD_INSERT, k, $urandom);
      end else if (pick < 96) begin
        k = last_ins_key - $urandom_range(0, 60);
        if (pick < 88) k = {$urandom, $urandom};
        send_request(CMD_SEARCH, k, $urandom);
      end else if (pick < 98) begin
        k = (live > 0) ? shadow_key[head_ptr[0]] + $urandom_range(0, 2) : last_ins_key;
        send_request(CMD_TRUNCATE, k, $urandom);
      end else begin
        send_request(CMD_NONE, {$urandom, $urandom}, $urandom);
      end
      if (i == 150) drain();
    end
    drain();
  endtask

  // fill the ring, hit the full case, then wrap slots around
  task automatic test_full_pool();
    logic [KEY_W-1:0] base;
    gap_pct = 0;
    base = last_ins_key;
    while (live < SLOTS - 1) send_request(CMD_INSERT, base + live / 3, $urandom);
    send_request(CMD_INSERT, base + 400, 32'hDEAD_BEEF);     // pool full
    send_request(CMD_SEARCH, base + 100, '0);
    send_request(CMD_TRUNCATE, base + 200, '0);
    for (int i = 0; i < 20; i++) send_request(CMD_INSERT, base + 400 + i, $urandom);
    send_request(CMD_SEARCH, base + 410, '0);
    send_request(CMD_TRUNCATE, base + 300, '0);
    drain();
  endtask

  task automatic test_top_key();
    send_request(CMD_INSERT, '1, 32'hFFFF_FFFF);
    send_request(CMD_SEARCH, '1, '0);
    send_request(CMD_TRUNCATE, '1, '0);
    send_request(CMD_INSERT, 64'd1, 32'h2);                  // below saturated last key
    send_request(CMD_INSERT, '1, 32'h3);
    drain();
  endtask

  initial begin
    shadow_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_seeds();
    test_random(250);
    test_full_pool();
    test_top_key();
    start <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && expected_rsp.size() == 0) begin
      $display("tb_append_only_skiplist_index_core: clean");
    end else begin
      $display("tb_append_only_skiplist_index_core: errors");
    end
    $finish;
  end

endmodule

### sim.f
src/aosl_pkg.sv
src/aosl_ram.sv
src/append_only_skiplist_index_core.sv
verif/tb_append_only_skiplist_index_core.sv
